FILE: design/sshb_pkg.sv
// Package for the soft-start H-bridge motor control block.
// Holds the mode and sequencer types, the command characters and the register defaults.
// Depends on nothing; every other file of the block imports it.
package sshb_pkg;

    localparam int RAMP_W     = 16;
    localparam int DUTY_W     = 8;
    localparam int PROD_W     = RAMP_W + DUTY_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [RAMP_W-1:0] RAMP_MS_RESET  = 16'd1000;
    localparam logic [DUTY_W-1:0] MAX_DUTY_RESET = 8'd255;
    localparam logic [RAMP_W-1:0] ELAPSED_MAX    = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_MS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY = 1'd1;

    localparam logic [7:0] CMD_FWD_UC  = 8'h46;
    localparam logic [7:0] CMD_FWD_LC  = 8'h66;
    localparam logic [7:0] CMD_BWD_UC  = 8'h42;
    localparam logic [7:0] CMD_BWD_LC  = 8'h62;
    localparam logic [7:0] CMD_STOP_UC = 8'h53;
    localparam logic [7:0] CMD_STOP_LC = 8'h73;

    localparam logic DIR_FORWARD  = 1'b0;
    localparam logic DIR_BACKWARD = 1'b1;

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_RAMPING = 2'd1,
        MODE_RUNNING = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic              dir;
        logic              up_held;
        logic              down_held;
        logic [RAMP_W-1:0] elapsed;
    } motor_state_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [7:0] cmd_byte;
        logic       up_level;
        logic       down_level;
        logic       ms_tick;
    } pass_item_t;

    typedef struct packed {
        motor_state_t state;
        logic         need_div;
    } pass_result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_LOAD
    } top_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_MUL,
        DIV_DIV,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

FILE: design/sshb_ifs.sv
// Valid/ready channel interfaces for the control passes and for the drive results.
// Depends on sshb_pkg for the field widths.
interface sshb_in_if
    import sshb_pkg::*;
;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [7:0] cmd_byte;
    logic       up_level;
    logic       down_level;
    logic       ms_tick;

    modport source (output valid, cmd_valid, cmd_byte, up_level, down_level, ms_tick,
                    input ready);
    modport sink   (input valid, cmd_valid, cmd_byte, up_level, down_level, ms_tick,
                    output ready);
endinterface

interface sshb_out_if
    import sshb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              drive_a;
    logic              drive_b;
    logic [DUTY_W-1:0] duty;
    logic [1:0]        motor_mode;

    modport source (output valid, drive_a, drive_b, duty, motor_mode, input ready);
    modport sink   (input valid, drive_a, drive_b, duty, motor_mode, output ready);
endinterface

FILE: design/soft_start_hbridge_motor_control.sv
// A pass that leaves the motor stopped or running goes from the idle state to the load
// state and into the output register; a pass that leaves it ramping first waits in the
// calc state for the bit-serial duty unit (eight multiply steps and eight divide steps,
// one bit a cycle). A new pass is taken only once the last result has been loaded.
// Reset (rst_n, asynchronous, active low) stops the motor, selects forward, clears the
// held buttons and the elapsed count, and loads ramp_ms = 1000 and max_duty = 255.
module soft_start_hbridge_motor_control
    import sshb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    sshb_in_if.sink               in_ch,
    sshb_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers; the user writes them only while the block is idle, unchecked.
    logic [RAMP_W-1:0] ramp_ms_reg;
    logic [DUTY_W-1:0] max_duty_reg;

    // Motor state as it stands after the last accepted pass.
    motor_state_t motor_reg;

    top_state_t top_state_reg, top_state_next;
    logic [DUTY_W-1:0] ramp_duty_reg;

    logic              out_valid_reg;
    logic              drive_a_reg;
    logic              drive_b_reg;
    logic [DUTY_W-1:0] duty_reg;
    logic [1:0]        mode_out_reg;

    pass_item_t   item;
    pass_result_t pass_res;
    div_status_t  div_stat;
    logic [DUTY_W-1:0] div_quot;
    logic in_xfer;
    logic out_free;
    logic load_out;
    logic div_start;
    logic [DUTY_W-1:0] duty_sel;
    logic moving;

    assign item = '{cmd_valid:  in_ch.cmd_valid,
                    cmd_byte:   in_ch.cmd_byte,
                    up_level:   in_ch.up_level,
                    down_level: in_ch.down_level,
                    ms_tick:    in_ch.ms_tick};

    // A new pass is taken whenever the sequencer is idle; the output register holds
    // the previous result independently until its transfer.
    assign in_ch.ready = (top_state_reg == ST_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    sshb_ctrl u_ctrl (
        .cur     (motor_reg),
        .item    (item),
        .ramp_ms (ramp_ms_reg),
        .res     (pass_res)
    );

    // The duty unit starts on the transfer itself, with the updated elapsed count.
    assign div_start = in_xfer && pass_res.need_div;

    sshb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .elapsed  (pass_res.state.elapsed),
        .max_duty (max_duty_reg),
        .ramp_ms  (ramp_ms_reg),
        .status   (div_stat),
        .quot     (div_quot)
    );

    always_comb
    begin
        top_state_next = top_state_reg;
        unique case (top_state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    top_state_next = pass_res.need_div ? ST_CALC : ST_LOAD;
                end
            end
            ST_CALC: if (div_stat.done) top_state_next = ST_LOAD;
            ST_LOAD: if (out_free) top_state_next = ST_IDLE;
            default: top_state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        load_out = (top_state_reg == ST_LOAD) && out_free;
    end

    // Stopped gives zero duty, ramping the computed value, anything else full duty.
    always_comb
    begin
        case (motor_reg.mode)
            MODE_STOPPED: duty_sel = '0;
            MODE_RAMPING: duty_sel = ramp_duty_reg;
            default:      duty_sel = max_duty_reg;
        endcase
    end

    assign moving = (motor_reg.mode != MODE_STOPPED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_ms_reg   <= RAMP_MS_RESET;
            max_duty_reg  <= MAX_DUTY_RESET;
            motor_reg     <= '{mode: MODE_STOPPED, dir: DIR_FORWARD, up_held: 1'b0,
                               down_held: 1'b0, elapsed: '0};
            top_state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RAMP_MS:  ramp_ms_reg  <= cfg_wdata[RAMP_W-1:0];
                    CFG_MAX_DUTY: max_duty_reg <= cfg_wdata[DUTY_W-1:0];
                    default:      ;
                endcase
            end
            if (in_xfer)
            begin
                motor_reg <= pass_res.state;
            end
            top_state_reg <= top_state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_stat.done)
        begin
            ramp_duty_reg <= div_quot;
        end
        if (load_out)
        begin
            drive_a_reg  <= moving && (motor_reg.dir == DIR_FORWARD);
            drive_b_reg  <= moving && (motor_reg.dir == DIR_BACKWARD);
            duty_reg     <= duty_sel;
            mode_out_reg <= motor_reg.mode;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.drive_a    = drive_a_reg;
    assign out_ch.drive_b    = drive_b_reg;
    assign out_ch.duty       = duty_reg;
    assign out_ch.motor_mode = mode_out_reg;

    // The duty unit only finishes while the sequencer waits for it.
    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (top_state_reg == ST_CALC))
        else $error("duty unit finished outside the calculation state");

    // A ramp duty never exceeds the full-speed duty.
    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (div_quot <= max_duty_reg))
        else $error("ramp duty above max_duty");

    // The bridge is never driven in both directions at once.
    a_no_shoot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(drive_a_reg && drive_b_reg))
        else $error("both bridge inputs high");

    // A result loaded from the sequencer is offered in the next cycle.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("loaded result not offered");

    // A stopped motor reports zero duty and no drive.
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && mode_out_reg == MODE_STOPPED)
        |-> (duty_reg == '0 && !drive_a_reg && !drive_b_reg))
        else $error("stopped result with drive or duty");

endmodule

FILE: design/sshb_ctrl.sv
// Control pass logic: tick, command, button edges and the ramp end check.
// Depends on sshb_pkg.
module sshb_ctrl
    import sshb_pkg::*;
(
    input  motor_state_t      cur,
    input  pass_item_t        item,
    input  logic [RAMP_W-1:0] ramp_ms,
    output pass_result_t      res
);

    function automatic motor_state_t begin_motion(input motor_state_t s, input logic d);
        motor_state_t r;
        r = s;
        if (s.mode == MODE_STOPPED)
        begin
            r.dir     = d;
            r.mode    = MODE_RAMPING;
            r.elapsed = '0;
        end
        return r;
    endfunction

    always_comb
    begin
        motor_state_t s;
        s = cur;

        if (item.ms_tick && s.mode == MODE_RAMPING && s.elapsed != ELAPSED_MAX)
        begin
            s.elapsed = s.elapsed + RAMP_W'(1);
        end

        if (item.cmd_valid)
        begin
            unique case (item.cmd_byte) inside
                CMD_FWD_UC, CMD_FWD_LC:   s = begin_motion(s, DIR_FORWARD);
                CMD_BWD_UC, CMD_BWD_LC:   s = begin_motion(s, DIR_BACKWARD);
                CMD_STOP_UC, CMD_STOP_LC: s.mode = MODE_STOPPED;
                default:                  ;
            endcase
        end

        if (item.up_level && !s.up_held)
        begin
            s.up_held = 1'b1;
            s = begin_motion(s, DIR_FORWARD);
        end
        else if (!item.up_level && s.up_held)
        begin
            s.up_held = 1'b0;
            s.mode    = MODE_STOPPED;
        end

        if (item.down_level && !s.down_held)
        begin
            s.down_held = 1'b1;
            s = begin_motion(s, DIR_BACKWARD);
        end
        else if (!item.down_level && s.down_held)
        begin
            s.down_held = 1'b0;
            s.mode      = MODE_STOPPED;
        end

        res.need_div = 1'b0;
        if (s.mode == MODE_RAMPING)
        begin
            if (s.elapsed >= ramp_ms)
            begin
                s.mode = MODE_RUNNING;
            end
            else
            begin
                res.need_div = 1'b1;
            end
        end

        res.state = s;
    end

endmodule

FILE: design/sshb_div.sv
// Bit-serial ramp duty unit: shift-and-add multiply, then restoring division.
// Depends on sshb_pkg. The quotient is at most max_duty because elapsed is below ramp_ms.
module sshb_div
    import sshb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAMP_W-1:0] elapsed,
    input  logic [DUTY_W-1:0] max_duty,
    input  logic [RAMP_W-1:0] ramp_ms,
    output div_status_t       status,
    output logic [DUTY_W-1:0] quot
);

    localparam int CNT_W = $clog2(DUTY_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DUTY_W - 1);

    div_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RAMP_W-1:0] elap_reg, elap_next;
    logic [RAMP_W-1:0] ramp_reg, ramp_next;
    logic [DUTY_W-1:0] mult_reg, mult_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [RAMP_W:0]   trial;
    logic [RAMP_W:0]   diff;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE: if (start) state_next = DIV_MUL;
            DIV_MUL:  if (cnt_reg == CNT_LAST) state_next = DIV_DIV;
            DIV_DIV:  if (cnt_reg == CNT_LAST) state_next = DIV_DONE;
            DIV_DONE: state_next = DIV_IDLE;
            default:  state_next = DIV_IDLE;
        endcase
    end

    always_comb
    begin
        status.busy = (state_reg != DIV_IDLE);
        status.done = (state_reg == DIV_DONE);
    end

    // One multiplier bit, most significant first, or one quotient bit per cycle.
    always_comb
    begin
        cnt_next  = cnt_reg;
        elap_next = elap_reg;
        ramp_next = ramp_reg;
        mult_next = mult_reg;
        acc_next  = acc_reg;
        trial     = {acc_reg[PROD_W-1:DUTY_W], acc_reg[DUTY_W-1]};
        diff      = trial - {1'b0, ramp_reg};
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    cnt_next  = '0;
                    elap_next = elapsed;
                    ramp_next = ramp_ms;
                    mult_next = max_duty;
                    acc_next  = '0;
                end
            end
            DIV_MUL:
            begin
                acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                         + (mult_reg[DUTY_W-1] ? {{DUTY_W{1'b0}}, elap_reg} : '0);
                mult_next = {mult_reg[DUTY_W-2:0], 1'b0};
                cnt_next  = cnt_reg + CNT_W'(1);
            end
            DIV_DIV:
            begin
                if (trial >= {1'b0, ramp_reg})
                begin
                    acc_next = {diff[RAMP_W-1:0], acc_reg[DUTY_W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = {trial[RAMP_W-1:0], acc_reg[DUTY_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elap_reg <= elap_next;
        ramp_reg <= ramp_next;
        mult_reg <= mult_next;
        acc_reg  <= acc_next;
    end

    assign quot = acc_reg[DUTY_W-1:0];

endmodule

FILE: tb/sv/motor_drive_checker_pkg.sv
// Checker class for the soft-start H-bridge testbench: predicts the drive outputs of each pass.
// Depends on sshb_pkg for the mode type, the command characters and the register defaults.
package motor_drive_checker_pkg;
    import sshb_pkg::*;

    typedef struct packed {
        logic              drive_a;
        logic              drive_b;
        logic [DUTY_W-1:0] duty;
        logic [1:0]        motor_mode;
    } drive_word_t;

    class motor_drive_checker;
        mode_t             mode;
        logic              dir;
        logic              up_held;
        logic              down_held;
        logic [RAMP_W-1:0] elapsed;
        logic [RAMP_W-1:0] ramp_ms;
        logic [DUTY_W-1:0] max_duty;
        drive_word_t       expected_drive[$];
        int                passes_noted;
        int                results_checked;
        int                mismatches;
        int                mode_seen[3];

        function new();
            mode            = MODE_STOPPED;
            dir             = DIR_FORWARD;
            up_held         = 1'b0;
            down_held       = 1'b0;
            elapsed         = '0;
            ramp_ms         = RAMP_MS_RESET;
            max_duty        = MAX_DUTY_RESET;
            passes_noted    = 0;
            results_checked = 0;
            mismatches      = 0;
            foreach (mode_seen[i])
                mode_seen[i] = 0;
        endfunction

        function void set_config(logic [RAMP_W-1:0] ramp, logic [DUTY_W-1:0] duty);
            ramp_ms  = ramp;
            max_duty = duty;
        endfunction

        function int pending();
            return expected_drive.size();
        endfunction

        // A start only counts from stopped; it latches the direction and restarts the ramp.
        function void try_start(logic new_dir);
            if (mode == MODE_STOPPED)
            begin
                dir     = new_dir;
                mode    = MODE_RAMPING;
                elapsed = '0;
            end
        endfunction

        function void note_pass(pass_item_t p);
            drive_word_t       want;
            logic [31:0]       product;
            logic [31:0]       quotient;
            logic [DUTY_W-1:0] duty;

            passes_noted++;
            if (p.ms_tick && mode == MODE_RAMPING && elapsed != ELAPSED_MAX)
                elapsed++;

            if (p.cmd_valid)
            begin
                case (p.cmd_byte)
                    CMD_FWD_UC, CMD_FWD_LC:   try_start(DIR_FORWARD);
                    CMD_BWD_UC, CMD_BWD_LC:   try_start(DIR_BACKWARD);
                    CMD_STOP_UC, CMD_STOP_LC: mode = MODE_STOPPED;
                    default: ;
                endcase
            end

            if (p.up_level && !up_held)
            begin
                up_held = 1'b1;
                try_start(DIR_FORWARD);
            end
            else if (!p.up_level && up_held)
            begin
                up_held = 1'b0;
                mode    = MODE_STOPPED;
            end

            if (p.down_level && !down_held)
            begin
                down_held = 1'b1;
                try_start(DIR_BACKWARD);
            end
            else if (!p.down_level && down_held)
            begin
                down_held = 1'b0;
                mode      = MODE_STOPPED;
            end

            duty = '0;
            if (mode == MODE_RAMPING)
            begin
                if (elapsed >= ramp_ms)
                begin
                    mode = MODE_RUNNING;
                    duty = max_duty;
                end
                else
                begin
                    product  = 32'(elapsed) * 32'(max_duty);
                    quotient = product / 32'(ramp_ms);
                    duty     = quotient[DUTY_W-1:0];
                end
            end
            else if (mode != MODE_STOPPED)
                duty = max_duty;

            want.drive_a    = (mode != MODE_STOPPED) && (dir == DIR_FORWARD);
            want.drive_b    = (mode != MODE_STOPPED) && (dir == DIR_BACKWARD);
            want.duty       = duty;
            want.motor_mode = mode;
            expected_drive.push_back(want);
        endfunction

        task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
            $display("Mismatch on result %0d, %s: got %0h, expected %0h",
                     results_checked, what, got, want);
            mismatches++;
        endtask

        task check_result(drive_word_t got);
            drive_word_t want;

            results_checked++;
            if (expected_drive.size() == 0)
            begin
                report_mismatch("result with no pass waiting", 16'(got), 16'h0);
                return;
            end
            want = expected_drive.pop_front();
            if (want.motor_mode < 2'd3)
                mode_seen[want.motor_mode]++;
            if (got.drive_a !== want.drive_a)
                report_mismatch("drive_a", 16'(got.drive_a), 16'(want.drive_a));
            if (got.drive_b !== want.drive_b)
                report_mismatch("drive_b", 16'(got.drive_b), 16'(want.drive_b));
            if (got.duty !== want.duty)
                report_mismatch("duty", 16'(got.duty), 16'(want.duty));
            if (got.motor_mode !== want.motor_mode)
                report_mismatch("motor_mode", 16'(got.motor_mode), 16'(want.motor_mode));
        endtask
    endclass

endpackage

FILE: tb/sv/testbench.sv
// Top-level testbench for soft_start_hbridge_motor_control: directed and random control passes.
// Depends on sshb_pkg, the sshb channel interfaces and motor_drive_checker_pkg.
module testbench;
    import sshb_pkg::*;
    import motor_drive_checker_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    sshb_in_if  in_ch();
    sshb_out_if out_ch();

    soft_start_hbridge_motor_control u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    motor_drive_checker board = new();

    // When steady_flow is set, neither side inserts idle cycles, so passes go back to back
    // and results are taken as soon as they appear.
    bit                steady_flow   = 1'b0;
    // Tracks whether the pass channel is currently offering a pass, so that valid is only
    // ever assigned once per clock edge.
    bit                pass_offered  = 1'b0;
    // Button levels as the random sequences currently hold them.
    logic              tb_up         = 1'b0;
    logic              tb_down       = 1'b0;
    logic [RAMP_W-1:0] cur_ramp      = RAMP_MS_RESET;
    int                passes_sent   = 0;
    int                settings_used = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // A generous ceiling: the slowest correct run is well under a tenth of this.
    initial
    begin
        #2000000;
        $display("testbench failed");
        $finish;
    end

    // Both monitors sample at the rising edge, so they see the values that the block saw.
    // The input side is noted before the output side, though the block's latency means a
    // result never shares an edge with its own pass.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                board.note_pass('{cmd_valid:  in_ch.cmd_valid,
                                  cmd_byte:   in_ch.cmd_byte,
                                  up_level:   in_ch.up_level,
                                  down_level: in_ch.down_level,
                                  ms_tick:    in_ch.ms_tick});
            if (out_ch.valid && out_ch.ready)
                board.check_result('{drive_a:    out_ch.drive_a,
                                     drive_b:    out_ch.drive_b,
                                     duty:       out_ch.duty,
                                     motor_mode: out_ch.motor_mode});
        end
    end

    function automatic int draw_wait();
        return steady_flow ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic logic [7:0] start_byte();
        case ($urandom_range(0, 3))
            0:       return CMD_FWD_UC;
            1:       return CMD_FWD_LC;
            2:       return CMD_BWD_UC;
            default: return CMD_BWD_LC;
        endcase
    endfunction

    function automatic logic [7:0] stop_byte();
        return $urandom_range(0, 1) ? CMD_STOP_UC : CMD_STOP_LC;
    endfunction

    function automatic pass_item_t pass_of(logic cv, logic [7:0] cb, logic up, logic dn,
                                           logic tick);
        pass_item_t p;
        p.cmd_valid  = cv;
        p.cmd_byte   = cb;
        p.up_level   = up;
        p.down_level = dn;
        p.ms_tick    = tick;
        return p;
    endfunction

    // A pass with no command that keeps the buttons where the sequence holds them. The
    // byte is random since it must be ignored when cmd_valid is low.
    function automatic pass_item_t idle_pass();
        return pass_of(1'b0, 8'($urandom), tb_up, tb_down, $urandom_range(0, 99) < 85);
    endfunction

    // Offers one pass after a random gap and returns at the edge of its transfer. Valid is
    // left high, so that a following pass with no gap goes straight out.
    task automatic send_pass(input pass_item_t p);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            if (pass_offered)
                in_ch.valid <= 1'b0;
            pass_offered = 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cmd_valid  <= p.cmd_valid;
        in_ch.cmd_byte   <= p.cmd_byte;
        in_ch.up_level   <= p.up_level;
        in_ch.down_level <= p.down_level;
        in_ch.ms_tick    <= p.ms_tick;
        pass_offered = 1'b1;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        passes_sent++;
    endtask

    // Withdraws the pass channel and holds off until every expected result has come back.
    // One edge goes by first, so that the monitor has noted the pass that was transferred
    // at the edge on which this task was called.
    task automatic flush_passes();
        if (pass_offered)
            in_ch.valid <= 1'b0;
        pass_offered = 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
    endtask

    // Registers are only written with the block drained. Every pass gives exactly one
    // result, so once nothing is pending the block is idle; the short pause that follows
    // is a margin only. The upper byte of the duty write is random and must be dropped.
    task automatic configure(input logic [RAMP_W-1:0] ramp, input logic [DUTY_W-1:0] duty);
        flush_passes();
        repeat (20) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RAMP_MS;
        cfg_wdata <= ramp;
        @(posedge clk);
        cfg_index <= CFG_MAX_DUTY;
        cfg_wdata <= {8'($urandom), duty};
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_config(ramp, duty);
        cur_ramp = ramp;
        settings_used++;
    endtask

    // One well-formed motion: a start by command or button press, a stretch of ticking
    // passes long enough to reach the end of the ramp most of the time, with the odd
    // ignored start or stray byte, and then usually a stop by command or release.
    task automatic run_motion_sequence();
        pass_item_t p;
        int         limit;
        int         hold_len;

        limit = int'(cur_ramp) + int'(cur_ramp) / 4 + 4;
        if (limit > 150)
            limit = 150;
        hold_len = $urandom_range(0, limit);

        p = idle_pass();
        case ($urandom_range(0, 3))
            0:
            begin
                p.cmd_valid = 1'b1;
                p.cmd_byte  = $urandom_range(0, 1) ? CMD_FWD_UC : CMD_FWD_LC;
            end
            1:
            begin
                p.cmd_valid = 1'b1;
                p.cmd_byte  = $urandom_range(0, 1) ? CMD_BWD_UC : CMD_BWD_LC;
            end
            2:
            begin
                if (!tb_up)
                begin
                    tb_up      = 1'b1;
                    p.up_level = 1'b1;
                end
                else
                begin
                    p.cmd_valid = 1'b1;
                    p.cmd_byte  = CMD_FWD_UC;
                end
            end
            default:
            begin
                if (!tb_down)
                begin
                    tb_down      = 1'b1;
                    p.down_level = 1'b1;
                end
                else
                begin
                    p.cmd_valid = 1'b1;
                    p.cmd_byte  = CMD_BWD_LC;
                end
            end
        endcase
        send_pass(p);

        repeat (hold_len)
        begin
            p = idle_pass();
            if ($urandom_range(0, 9) == 0)
            begin
                p.cmd_valid = 1'b1;
                p.cmd_byte  = $urandom_range(0, 1) ? start_byte() : 8'($urandom);
            end
            send_pass(p);
        end

        p = idle_pass();
        case ($urandom_range(0, 3))
            0:
            begin
                p.cmd_valid = 1'b1;
                p.cmd_byte  = stop_byte();
            end
            1, 2:
            begin
                // Release whatever is held; in either case a stop command is sent too.
                if (tb_up || tb_down)
                begin
                    tb_up        = 1'b0;
                    tb_down      = 1'b0;
                    p.up_level   = 1'b0;
                    p.down_level = 1'b0;
                end
                if (!p.cmd_valid)
                begin
                    p.cmd_valid = 1'b1;
                    p.cmd_byte  = stop_byte();
                end
            end
            default: ;
        endcase
        send_pass(p);
    endtask

    // The result side stalls for a fresh random number of cycles before each transfer.
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (out_ch.valid !== 1'b1);
        end
    end

    initial
    begin
        logic [RAMP_W-1:0] phase_ramp [9];
        logic [DUTY_W-1:0] phase_duty [9];
        pass_item_t        noise;
        int                phase_start;

        phase_ramp = '{16'd1, 16'd2, 16'd5, 16'd16, 16'hFFFF, 16'd90, 16'd3, 16'd40, 16'd7};
        phase_duty = '{8'd255, 8'd0, 8'd128, 8'd255, 8'd255, 8'd77, 8'd1, 8'd200, 8'd255};

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_RAMP_MS;
        cfg_wdata        = '0;
        in_ch.valid      = 1'b0;
        in_ch.cmd_valid  = 1'b0;
        in_ch.cmd_byte   = '0;
        in_ch.up_level   = 1'b0;
        in_ch.down_level = 1'b0;
        in_ch.ms_tick    = 1'b0;
        out_ch.ready     = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first with the reset settings (ramp of 1000, full duty). A tick
        // in the same pass as a start is lost, since the start clears the count.
        send_pass(pass_of(1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
        send_pass(pass_of(1'b1, CMD_FWD_UC, 1'b0, 1'b0, 1'b1));
        send_pass(pass_of(1'b0, 8'hFF, 1'b0, 1'b0, 1'b1));
        // A start while moving changes nothing; nor do an unknown byte and a stop byte
        // that arrives without cmd_valid.
        send_pass(pass_of(1'b1, CMD_BWD_UC, 1'b0, 1'b0, 1'b1));
        send_pass(pass_of(1'b1, 8'hFF, 1'b0, 1'b0, 1'b0));
        send_pass(pass_of(1'b0, CMD_STOP_UC, 1'b0, 1'b0, 1'b1));
        send_pass(pass_of(1'b1, CMD_STOP_LC, 1'b0, 1'b0, 1'b1));
        // Stopping an already stopped motor has no effect.
        send_pass(pass_of(1'b1, CMD_STOP_UC, 1'b0, 1'b0, 1'b0));
        send_pass(pass_of(1'b1, CMD_BWD_LC, 1'b0, 1'b0, 1'b0));

        // A two-tick ramp shows the divided duty and then the switch to running.
        configure(16'd2, 8'd200);
        send_pass(pass_of(1'b0, 8'h00, 1'b0, 1'b0, 1'b1));
        send_pass(pass_of(1'b0, 8'h00, 1'b0, 1'b0, 1'b1));
        // While running, a new maximum duty takes effect at once.
        configure(16'd2, 8'd255);
        send_pass(pass_of(1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
        // Presses while moving are only marked as held; releasing one button stops the
        // motor although the other is still down.
        send_pass(pass_of(1'b0, 8'h00, 1'b1, 1'b0, 1'b1));
        send_pass(pass_of(1'b0, 8'h00, 1'b1, 1'b1, 1'b1));
        send_pass(pass_of(1'b0, 8'h00, 1'b0, 1'b1, 1'b0));
        send_pass(pass_of(1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
        // A press from stopped starts the motor; the other button is then ignored until
        // its release stops everything.
        send_pass(pass_of(1'b0, 8'h00, 1'b1, 1'b0, 1'b1));
        send_pass(pass_of(1'b0, 8'h00, 1'b1, 1'b1, 1'b1));
        send_pass(pass_of(1'b0, 8'h00, 1'b1, 1'b0, 1'b0));
        send_pass(pass_of(1'b1, CMD_FWD_LC, 1'b1, 1'b0, 1'b1));
        // Order within a pass: command first, then the up edge, then the down edge.
        send_pass(pass_of(1'b1, CMD_STOP_UC, 1'b0, 1'b1, 1'b0));
        send_pass(pass_of(1'b1, CMD_FWD_UC, 1'b0, 1'b0, 1'b1));
        send_pass(pass_of(1'b1, CMD_BWD_UC, 1'b1, 1'b1, 1'b0));
        send_pass(pass_of(1'b0, 8'h00, 1'b0, 1'b0, 1'b1));

        // The longest ramp: a fresh start gives a duty of zero for a long while.
        configure(16'hFFFF, 8'd255);
        send_pass(pass_of(1'b1, CMD_FWD_UC, 1'b0, 1'b0, 1'b1));
        send_pass(pass_of(1'b0, 8'h00, 1'b0, 1'b0, 1'b1));

        // Random part: a series of register settings, each with a block of motion
        // sequences and a little noise between them. The motor state carries over from
        // one setting to the next, so a new duty may land on a running motor.
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph >= 7)
                configure(16'($urandom_range(1, 64)), 8'($urandom_range(0, 255)));
            else
                configure(phase_ramp[ph], phase_duty[ph]);
            steady_flow = ($urandom_range(0, 2) == 0);
            phase_start = passes_sent;
            while (passes_sent - phase_start < 105)
            begin
                if ($urandom_range(0, 4) == 0)
                    steady_flow = !steady_flow;
                run_motion_sequence();
                repeat ($urandom_range(0, 2))
                begin
                    noise   = 12'($urandom);
                    tb_up   = noise.up_level;
                    tb_down = noise.down_level;
                    send_pass(noise);
                end
                // Now and then the sender holds back until the block has drained.
                if ($urandom_range(0, 14) == 0)
                    flush_passes();
            end
        end

        flush_passes();
        repeat (30) @(posedge clk);

        $display("Sent %0d control passes under %0d register settings; %0d results checked.",
                 passes_sent, settings_used, board.results_checked);
        $display("Modes seen in the results: %0d stopped, %0d ramping, %0d running.",
                 board.mode_seen[0], board.mode_seen[1], board.mode_seen[2]);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
